FILE: rtl/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsa_pkg
// Shared widths, codes and controller/datapath link types for the slab
// allocator.
// ============================================================================
package bsa_pkg;

    localparam int SLABS_DEF     = 128;
    localparam int MAX_BATCH_DEF = 64;

    localparam int OPCODE_W      = 2;
    localparam int COUNT_FIELD_W = 7;
    localparam int IDX_FIELD_W   = 7;
    localparam int STATUS_W      = 2;
    localparam int CFG_W         = 8;

    localparam logic [CFG_W-1:0] SLAB_COUNT_RESET = 8'd128;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_ACQ_ONE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ACQ_MANY = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] RS_GRANTED   = 2'd0;
    localparam logic [STATUS_W-1:0] RS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] RS_EMPTY     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_REJECT,
        ST_GRANT
    } bsa_state_t;

    // controller -> datapath
    typedef struct packed {
        logic req_load;     // latch the accepted request
        logic release_slab; // free the slab named by the input word
        logic sel_scratch;  // point the finder at the scratch map
        logic scratch_load; // copy the free map into scratch
        logic scratch_step; // drop the lowest set bit of scratch
        logic k_clr;
        logic k_inc;
        logic grant;        // mark the lowest free slab busy and emit it
        logic grant_last;
        logic emit_fail;
        logic emit_empty;
    } bsa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_release;
        logic in_acquire;
        logic op_one;
        logic count_zero;
        logic count_big;
        logic any;
        logic k_last;
        logic load_ok;
    } bsa_stat_t;

endpackage
`default_nettype wire

FILE: rtl/bsa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsa_req_if
// Request channel: opcode, batch count and slab index with valid/ready.
// ============================================================================
interface bsa_req_if
    import bsa_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic [COUNT_FIELD_W-1:0] count;
    logic [IDX_FIELD_W-1:0]   slab_index;

    modport source (output valid, output opcode, output count, output slab_index,
                    input ready);
    modport sink   (input valid, input opcode, input count, input slab_index,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/bsa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsa_rsp_if
// Result channel: granted index, status and last flag with valid/ready.
// ============================================================================
interface bsa_rsp_if
    import bsa_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [IDX_FIELD_W-1:0] granted_index;
    logic [STATUS_W-1:0]    status;
    logic                   last;

    modport source (output valid, output granted_index, output status, output last,
                    input ready);
    modport sink   (input valid, input granted_index, input status, input last,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/bsa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsa_datapath
// Busy map, usable-count register, lowest-free finder, scan counter and
// result register.
// ============================================================================
module bsa_datapath
    import bsa_pkg::*;
#(
    parameter int SLABS     = SLABS_DEF,
    parameter int MAX_BATCH = MAX_BATCH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_W-1:0]         cfg_wdata,
    input  wire logic [OPCODE_W-1:0]      in_opcode,
    input  wire logic [COUNT_FIELD_W-1:0] in_count,
    input  wire logic [IDX_FIELD_W-1:0]   in_slab_index,
    input  wire logic                     out_ready,
    output logic                          out_valid,
    output logic [IDX_FIELD_W-1:0]        out_granted_index,
    output logic [STATUS_W-1:0]           out_status,
    output logic                          out_last,
    input  wire bsa_cmd_t                 cmd,
    output bsa_stat_t                     stat
);

    localparam int IDX_W = $clog2(SLABS);
    localparam int K_W   = $clog2(MAX_BATCH + 1);

    logic [CFG_W-1:0]         slab_count_reg;
    logic [SLABS-1:0]         busy_reg,  busy_next;
    logic [SLABS-1:0]         scratch_reg;
    logic [OPCODE_W-1:0]      req_op_reg;
    logic [COUNT_FIELD_W-1:0] req_count_reg;
    logic [K_W-1:0]           k_reg;

    logic                     out_valid_reg;
    logic [IDX_FIELD_W-1:0]   out_idx_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic                     out_last_reg;

    logic [CFG_W-1:0]         limit;
    logic [SLABS-1:0]         limit_mask;
    logic [SLABS-1:0]         avail;
    logic [SLABS-1:0]         find_vec;
    logic [SLABS-1:0]         find_onehot;
    logic [IDX_W-1:0]         find_idx;
    logic                     rel_hit;
    logic                     out_load;

    // usable count saturates at the number of physical slabs
    assign limit = (slab_count_reg > CFG_W'(SLABS)) ? CFG_W'(SLABS) : slab_count_reg;

    always_comb
    begin
        for (int i = 0; i < SLABS; i++)
        begin
            limit_mask[i] = CFG_W'(i) < limit;
        end
    end

    assign avail       = ~busy_reg & limit_mask;
    assign find_vec    = cmd.sel_scratch ? scratch_reg : avail;
    assign find_onehot = find_vec & (~find_vec + SLABS'(1));

    always_comb
    begin
        find_idx = '0;
        for (int i = 0; i < SLABS; i++)
        begin
            if (find_onehot[i])
            begin
                find_idx = find_idx | IDX_W'(i);
            end
        end
    end

    assign rel_hit = {1'b0, in_slab_index} < limit;

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.release_slab && rel_hit)
        begin
            busy_next[in_slab_index[IDX_W-1:0]] = 1'b0;
        end
        else if (cmd.grant)
        begin
            busy_next = busy_reg | find_onehot;
        end
    end

    assign out_load = cmd.grant || cmd.emit_fail || cmd.emit_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slab_count_reg <= SLAB_COUNT_RESET;
            busy_reg       <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                slab_count_reg <= cfg_wdata;
            end
            busy_reg <= busy_next;
            if (cmd.k_clr)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_reg + K_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_op_reg    <= in_opcode;
            req_count_reg <= in_count;
        end
        if (cmd.scratch_load)
        begin
            scratch_reg <= avail;
        end
        else if (cmd.scratch_step)
        begin
            scratch_reg <= scratch_reg & ~find_onehot;
        end
        if (cmd.grant)
        begin
            out_idx_reg    <= IDX_FIELD_W'(find_idx);
            out_status_reg <= RS_GRANTED;
            out_last_reg   <= cmd.grant_last;
        end
        else if (cmd.emit_fail)
        begin
            out_idx_reg    <= '0;
            out_status_reg <= RS_EXHAUSTED;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_empty)
        begin
            out_idx_reg    <= '0;
            out_status_reg <= RS_EMPTY;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_granted_index = out_idx_reg;
    assign out_status        = out_status_reg;
    assign out_last          = out_last_reg;

    assign stat.in_release = in_opcode == OP_RELEASE;
    assign stat.in_acquire = (in_opcode == OP_ACQ_ONE) || (in_opcode == OP_ACQ_MANY);
    assign stat.op_one     = req_op_reg == OP_ACQ_ONE;
    assign stat.count_zero = req_count_reg == '0;
    assign stat.count_big  = req_count_reg > COUNT_FIELD_W'(MAX_BATCH);
    assign stat.any        = |find_vec;
    assign stat.k_last     = (COUNT_FIELD_W'(k_reg) + COUNT_FIELD_W'(1)) == req_count_reg;
    assign stat.load_ok    = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

FILE: rtl/bsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsa_ctrl
// Request sequencer: decode, batch feasibility scan, grant issue.
// ============================================================================
module bsa_ctrl
    import bsa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output bsa_cmd_t       cmd,
    input  wire bsa_stat_t stat
);

    bsa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.in_release)
                    begin
                        cmd.release_slab = 1'b1;
                    end
                    else if (stat.in_acquire)
                    begin
                        cmd.req_load = 1'b1;
                        state_next   = ST_DECODE;
                    end
                end
            end
            ST_DECODE:
            begin
                if (stat.load_ok)
                begin
                    if (stat.op_one)
                    begin
                        if (stat.any)
                        begin
                            cmd.grant      = 1'b1;
                            cmd.grant_last = 1'b1;
                        end
                        else
                        begin
                            cmd.emit_fail = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    else if (stat.count_zero)
                    begin
                        cmd.emit_empty = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (stat.count_big)
                    begin
                        cmd.emit_fail = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scratch_load = 1'b1;
                        cmd.k_clr        = 1'b1;
                        state_next       = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // count free slabs one per cycle until the batch fits or none are left
                cmd.sel_scratch = 1'b1;
                if (!stat.any)
                begin
                    state_next = ST_REJECT;
                end
                else if (stat.k_last)
                begin
                    cmd.k_clr  = 1'b1;
                    state_next = ST_GRANT;
                end
                else
                begin
                    cmd.k_inc        = 1'b1;
                    cmd.scratch_step = 1'b1;
                end
            end
            ST_REJECT:
            begin
                if (stat.load_ok)
                begin
                    cmd.emit_fail = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_GRANT:
            begin
                if (stat.load_ok)
                begin
                    cmd.grant      = 1'b1;
                    cmd.grant_last = stat.k_last;
                    cmd.k_inc      = 1'b1;
                    if (stat.k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // never load the result register while it still holds an untaken word
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.grant || cmd.emit_fail || cmd.emit_empty) |-> stat.load_ok)
        else $error("result loaded over a pending word");

    // a batch that passed the scan always finds a free slab to grant
    a_grant_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GRANT && stat.load_ok) |-> stat.any)
        else $error("batch grant found no free slab");

    // a scan that reaches the requested count moves on to granting
    a_scan_to_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && stat.any && stat.k_last) |=> state_reg == ST_GRANT)
        else $error("scan completed without entering grant");

endmodule
`default_nettype wire

FILE: rtl/bitmap_slab_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bitmap_slab_allocator
// Busy-bitmap slab allocator with single, batch and release requests.
// ============================================================================
// Usage:
//   req carries one request word (opcode, count, slab_index); rsp returns
//   result words (granted_index, status, last). Both are valid/ready.
//   cfg_we/cfg_wdata write slab_count; write it only while the block is idle.
//   Release: taken from idle with no result; ready again the next cycle.
//   Acquire one: the result loads from the decode state once the result
//   register is free; the next request is taken once back in idle.
//   Acquire many of n slabs: a decode step, then a scan of the free map
//   at one slab per cycle, then n grant words, one per cycle while rsp
//   is ready. A batch that does not fit stops scanning at the first
//   missing slab and returns one exhausted word. Timing is set by the
//   single lowest-free finder, which serves both the scan and the grants.
//   One request is in flight at a time; req.ready is high only when idle.
//   A stalled rsp holds the result register and pauses the grant sequence;
//   the next request can still be taken while the final word waits.
//   Reset: all slabs free, slab_count = 128, no result pending.
// ============================================================================
module bitmap_slab_allocator
    import bsa_pkg::*;
#(
    parameter int SLABS     = SLABS_DEF,
    parameter int MAX_BATCH = MAX_BATCH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    bsa_req_if.sink               req,
    bsa_rsp_if.source             rsp
);

    bsa_cmd_t  cmd;
    bsa_stat_t stat;

    // sequencer: owns the request handshake, drives the datapath by command
    bsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // busy map, finder and result register
    bsa_datapath #(
        .SLABS     (SLABS),
        .MAX_BATCH (MAX_BATCH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_opcode         (req.opcode),
        .in_count          (req.count),
        .in_slab_index     (req.slab_index),
        .out_ready         (rsp.ready),
        .out_valid         (rsp.valid),
        .out_granted_index (rsp.granted_index),
        .out_status        (rsp.status),
        .out_last          (rsp.last),
        .cmd               (cmd),
        .stat              (stat)
    );

endmodule
`default_nettype wire

FILE: tb/bitmap_slab_allocator_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// bitmap_slab_allocator_tb
// Self-checking bench for the slab allocator. A directed table covers the
// field extremes, the empty, oversized and exhausted requests, the unused
// opcode, out-of-range releases and count changes. Randomized phases follow,
// each under its own slab count and idle/stall mix. Every result word is
// checked field by field against an in-bench busy-map predictor or a typed row.
// ============================================================================
module bitmap_slab_allocator_tb;
    import bsa_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 8;      // quiet cycles before a count write
    localparam int STALL_LIMIT   = 5000;   // cycles with no word moving
    localparam int REPORT_MAX    = 10;

    // opcode 3 has no meaning; the block must swallow it
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // random phases: slab count, sender idle %, receiver stall %, word count
    localparam int PHASES = 8;
    localparam int PHASE_SLABS [PHASES] = '{128, 1, 64, 128, 2, 100, 127, 128};
    localparam int PHASE_IDLE  [PHASES] = '{0, 48, 0, 7, 0, 48, 0, 0};
    localparam int PHASE_STALL [PHASES] = '{0, 0, 48, 7, 0, 0, 48, 0};
    localparam int PHASE_WORDS [PHASES] = '{50, 30, 50, 50, 30, 40, 40, 40};

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] slab;
        logic [STATUS_W-1:0]    status;
        logic                   last;
    } alloc_result_t;

    // CHECKED rows are judged by the predictor, TYPED rows carry their own
    // single result word, SET_COUNT rows write slab_count
    typedef enum logic [1:0] {
        ROW_CHECKED,
        ROW_TYPED,
        ROW_SET_COUNT
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [OPCODE_W-1:0]      op;
        logic [COUNT_FIELD_W-1:0] cnt;
        logic [IDX_FIELD_W-1:0]   idx;
        logic [CFG_W-1:0]         slabs;
        alloc_result_t            word;
    } plan_row_t;

    localparam int PLAN_ROWS = 26;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    bsa_req_if req_ch ();
    bsa_rsp_if rsp_ch ();

    bitmap_slab_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // predictor state: one busy bit per slab plus the programmed count
    logic [SLABS_DEF-1:0] slab_busy_map;
    logic [CFG_W-1:0]     slab_limit;

    alloc_result_t awaited_words [$];
    int            fails;
    int            idle_pct;
    int            stall_pct;
    int            quiet_cycles;
    plan_row_t     directed_plan [PLAN_ROWS];

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned usable_slabs();
        return (slab_limit > SLABS_DEF) ? SLABS_DEF : slab_limit;
    endfunction

    function automatic int unsigned free_slabs();
        int unsigned n;
        n = 0;
        for (int i = 0; i < usable_slabs(); i++)
            if (!slab_busy_map[i])
                n++;
        return n;
    endfunction

    task automatic owe_word(input bit record, input int unsigned slab,
                            input logic [STATUS_W-1:0] status, input logic last);
        alloc_result_t w;
        w.slab   = IDX_FIELD_W'(slab);
        w.status = status;
        w.last   = last;
        if (record)
            awaited_words = {awaited_words, w};
    endtask

    // Advance the busy map by one accepted request word; queue its results
    // unless the row already typed them in.
    task automatic allocate_or_free(input logic [OPCODE_W-1:0] op,
                                    input logic [COUNT_FIELD_W-1:0] cnt,
                                    input logic [IDX_FIELD_W-1:0] idx,
                                    input bit record);
        int unsigned limit;
        int unsigned k;
        bit          taken;
        limit = usable_slabs();
        case (op)
            OP_ACQ_ONE:
            begin
                taken = 1'b0;
                for (int i = 0; i < limit; i++)
                begin
                    if (!taken && !slab_busy_map[i])
                    begin
                        slab_busy_map[i] = 1'b1;
                        owe_word(record, i, RS_GRANTED, 1'b1);
                        taken = 1'b1;
                    end
                end
                if (!taken)
                    owe_word(record, 0, RS_EXHAUSTED, 1'b1);
            end
            OP_ACQ_MANY:
            begin
                if (cnt == 0)
                    owe_word(record, 0, RS_EMPTY, 1'b1);
                else if (cnt > MAX_BATCH_DEF || free_slabs() < cnt)
                    owe_word(record, 0, RS_EXHAUSTED, 1'b1);
                else
                begin
                    // all-or-nothing: lowest free slabs, ascending
                    k = 0;
                    for (int i = 0; i < limit; i++)
                    begin
                        if (k < cnt && !slab_busy_map[i])
                        begin
                            slab_busy_map[i] = 1'b1;
                            k++;
                            owe_word(record, i, RS_GRANTED, k == cnt);
                        end
                    end
                end
            end
            OP_RELEASE:
            begin
                // drop releases of slabs beyond the usable count
                if (idx < limit)
                    slab_busy_map[idx] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int want, input int got);
        fails++;
        if (fails <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_words.size() == 0)
                flag_mismatch("unexpected word, granted_index", -1, rsp_ch.granted_index);
            else
            begin
                want = awaited_words.pop_front();
                if (rsp_ch.granted_index !== want.slab)
                    flag_mismatch("granted_index", want.slab, rsp_ch.granted_index);
                if (rsp_ch.status !== want.status)
                    flag_mismatch("status", want.status, rsp_ch.status);
                if (rsp_ch.last !== want.last)
                    flag_mismatch("last", want.last, rsp_ch.last);
            end
        end
    end

    // Receiver: stall at random per the phase mix.
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: end the run when no word or write moves for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("bitmap_slab_allocator_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offer one request word and hold it until the block takes it. Valid is
    // lowered only when a gap follows, so back-to-back words keep it high.
    task automatic offer_word(input logic [OPCODE_W-1:0] op,
                              input logic [COUNT_FIELD_W-1:0] cnt,
                              input logic [IDX_FIELD_W-1:0] idx);
        if ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.count      <= cnt;
        req_ch.slab_index <= idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Write slab_count once the block has drained and gone quiet.
    task automatic write_slab_count(input logic [CFG_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        slab_limit  = value;
    endtask

    // Pick a random request. Keep the map from silting up by leaning toward
    // releases of busy slabs when few are free; every field bit still toggles.
    task automatic pick_request(output logic [OPCODE_W-1:0] op,
                                output logic [COUNT_FIELD_W-1:0] cnt,
                                output logic [IDX_FIELD_W-1:0] idx);
        int unsigned roll;
        int unsigned limit;
        int unsigned start;
        int unsigned free_n;
        int unsigned release_cut;
        bit          found;
        limit  = usable_slabs();
        free_n = free_slabs();
        roll   = $urandom_range(99);
        cnt    = COUNT_FIELD_W'($urandom);
        idx    = IDX_FIELD_W'($urandom);
        release_cut = (free_n < 16) ? 70 : 38;
        if (roll < 5)
            op = OP_UNUSED;
        else if (roll < release_cut)
        begin
            op = OP_RELEASE;
            // mostly free a slab that is really busy; otherwise any index
            if ($urandom_range(99) < 80)
            begin
                start = $urandom_range(limit - 1);
                found = 1'b0;
                for (int n = 0; n < limit; n++)
                begin
                    if (!found && slab_busy_map[(start + n) % limit])
                    begin
                        idx   = IDX_FIELD_W'((start + n) % limit);
                        found = 1'b1;
                    end
                end
            end
        end
        else if (roll < 66)
            op = OP_ACQ_ONE;
        else
        begin
            op   = OP_ACQ_MANY;
            roll = $urandom_range(99);
            if (roll < 6)
                cnt = '0;
            else if (roll < 12)
                cnt = COUNT_FIELD_W'($urandom_range(MAX_BATCH_DEF + 1, 127));
            else if (roll < 30)
                cnt = COUNT_FIELD_W'($urandom_range(1, MAX_BATCH_DEF));
            else
                cnt = COUNT_FIELD_W'($urandom_range(1, 6));
        end
    endtask

    function automatic plan_row_t chk(input logic [OPCODE_W-1:0] op,
                                      input logic [COUNT_FIELD_W-1:0] cnt,
                                      input logic [IDX_FIELD_W-1:0] idx);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_CHECKED;
        r.op    = op;
        r.cnt   = cnt;
        r.idx   = idx;
        return r;
    endfunction

    function automatic plan_row_t typed(input logic [OPCODE_W-1:0] op,
                                        input logic [COUNT_FIELD_W-1:0] cnt,
                                        input logic [IDX_FIELD_W-1:0] slab,
                                        input logic [STATUS_W-1:0] status);
        plan_row_t r;
        r             = chk(op, cnt, '0);
        r.kind        = ROW_TYPED;
        r.word.slab   = slab;
        r.word.status = status;
        r.word.last   = 1'b1;
        return r;
    endfunction

    function automatic plan_row_t set_count(input logic [CFG_W-1:0] value);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_SET_COUNT;
        r.slabs = value;
        return r;
    endfunction

    initial
    begin
        logic [OPCODE_W-1:0]      op;
        logic [COUNT_FIELD_W-1:0] cnt;
        logic [IDX_FIELD_W-1:0]   idx;

        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = '0;
        req_ch.count      = '0;
        req_ch.slab_index = '0;
        rsp_ch.ready      = 1'b0;
        fails             = 0;
        idle_pct          = 0;
        stall_pct         = 0;
        quiet_cycles      = 0;
        slab_busy_map     = '0;
        slab_limit        = SLAB_COUNT_RESET;

        directed_plan = '{
            set_count(8'd128),
            // fresh map: lowest slab, then the request-shape error codes
            typed(OP_ACQ_ONE,  7'd0,   7'd0, RS_GRANTED),
            typed(OP_ACQ_MANY, 7'd0,   7'd0, RS_EMPTY),
            typed(OP_ACQ_MANY, 7'd65,  7'd0, RS_EXHAUSTED),
            typed(OP_ACQ_MANY, 7'd127, 7'd0, RS_EXHAUSTED),
            chk(OP_ACQ_MANY, 7'd1,   7'd127),
            chk(OP_ACQ_MANY, 7'd64,  7'd85),
            chk(OP_RELEASE,  7'd127, 7'd0),
            chk(OP_RELEASE,  7'd0,   7'd127),   // already free
            chk(OP_UNUSED,   7'd127, 7'd127),
            chk(OP_ACQ_ONE,  7'd127, 7'd127),
            chk(OP_ACQ_MANY, 7'd62,  7'd0),     // fills the map to the top
            chk(OP_ACQ_ONE,  7'd0,   7'd0),     // nothing left
            chk(OP_ACQ_MANY, 7'd1,   7'd0),
            chk(OP_RELEASE,  7'd0,   7'd127),
            chk(OP_RELEASE,  7'd0,   7'd64),
            chk(OP_ACQ_MANY, 7'd2,   7'd0),     // split across the two halves
            // shrink to one slab: out-of-range release must be dropped
            set_count(8'd1),
            chk(OP_RELEASE,  7'd0,   7'd5),
            chk(OP_ACQ_ONE,  7'd0,   7'd0),
            chk(OP_RELEASE,  7'd0,   7'd0),
            chk(OP_ACQ_ONE,  7'd0,   7'd0),
            // grow back: the hidden busy bits must come back intact
            set_count(8'd128),
            chk(OP_ACQ_MANY, 7'd1,   7'd0),
            chk(OP_RELEASE,  7'd0,   7'd5),
            chk(OP_ACQ_ONE,  7'd0,   7'd0)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (directed_plan[r])
        begin
            if (directed_plan[r].kind == ROW_SET_COUNT)
                write_slab_count(directed_plan[r].slabs);
            else
            begin
                offer_word(directed_plan[r].op, directed_plan[r].cnt, directed_plan[r].idx);
                allocate_or_free(directed_plan[r].op, directed_plan[r].cnt,
                                 directed_plan[r].idx, directed_plan[r].kind == ROW_CHECKED);
                if (directed_plan[r].kind == ROW_TYPED)
                    awaited_words = {awaited_words, directed_plan[r].word};
            end
        end

        // random phases, each under its own count and idle/stall mix
        for (int p = 0; p < PHASES; p++)
        begin
            write_slab_count(CFG_W'(PHASE_SLABS[p]));
            idle_pct  = PHASE_IDLE[p];
            stall_pct = PHASE_STALL[p];
            for (int n = 0; n < PHASE_WORDS[p]; n++)
            begin
                pick_request(op, cnt, idx);
                offer_word(op, cnt, idx);
                allocate_or_free(op, cnt, idx, 1'b1);
            end
        end

        // drain, then leave room for any stray word to show up
        req_ch.valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("bitmap_slab_allocator_tb: clean");
        else
            $display("bitmap_slab_allocator_tb: errors");
        $finish;
    end

endmodule

FILE: bitmap_slab_allocator.f
rtl/bsa_pkg.sv
rtl/bsa_req_if.sv
rtl/bsa_rsp_if.sv
rtl/bsa_datapath.sv
rtl/bsa_ctrl.sv
rtl/bitmap_slab_allocator.sv
tb/bitmap_slab_allocator_tb.sv
